// ===== hdl/cubic_bezier_point_evaluator_assert.svh =====
// Assertion macros for the cubic Bezier point evaluator.
// Expects aclk and aresetn in the scope of the including module.
`ifndef CUBIC_BEZIER_POINT_EVALUATOR_ASSERT_SVH
`define CUBIC_BEZIER_POINT_EVALUATOR_ASSERT_SVH

// same-cycle implication
`define CBPE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CBPE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/cbpe_pkg.sv =====
// Package for the cubic Bezier point evaluator: widths, register indexes,
// control word type and the microcode table. No dependencies.
`timescale 1ns / 1ps

package cbpe_pkg;

    // Curve resolution and coordinate format
    localparam int STEPS_LOG2 = 7;
    localparam int STEPS      = 1 << STEPS_LOG2;
    localparam int COORD_BITS = 16;
    localparam int NUM_POINTS = 4;
    localparam int NUM_COMPS  = 3;

    // Derived widths
    localparam int IDX_W  = 8;                      // sample_index port
    localparam int SAMP_W = STEPS_LOG2 + 1;         // holds 0..STEPS
    localparam int SQ_W   = 2 * STEPS_LOG2 + 1;     // s^2, u^2
    localparam int TRI_W  = SAMP_W + 2;             // 3s, 3u
    localparam int WGT_W  = 3 * STEPS_LOG2 + 1;     // Bernstein weights
    localparam int OPB_W  = COORD_BITS + 1;         // signed multiplier B side
    localparam int PROD_W = WGT_W + 1 + OPB_W;      // full product
    localparam int ACC_W  = WGT_W + COORD_BITS;     // accumulated sum
    localparam int FRAC_W = 3 * STEPS_LOG2;         // divide by STEPS^3
    localparam int SEG_W  = 8;
    localparam int TIME_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 3 * COORD_BITS;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_ZERO     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_ONE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_TWO      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_THREE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_NUMBER = 3'd4;

    // Microcode fields
    typedef enum logic [2:0] {
        A_ZERO, A_S, A_U, A_S2, A_U2, A_3S, A_3U, A_WGT
    } a_sel_t;

    typedef enum logic [2:0] {
        B_S, B_U, B_S2, B_U2, B_COORD
    } b_sel_t;

    typedef enum logic [3:0] {
        WB_NONE, WB_S2, WB_U2, WB_W0, WB_W1, WB_W2, WB_W3, WB_ACC_LOAD, WB_ACC_ADD
    } wb_t;

    typedef enum logic [1:0] {
        SEQ_NEXT, SEQ_LOOP, SEQ_END
    } seq_t;

    // One control word. wb acts on the product registered by the previous step.
    typedef struct packed {
        a_sel_t     a_sel;
        logic [1:0] pt;
        b_sel_t     b_sel;
        wb_t        wb;
        seq_t       seq;
    } ucode_t;

    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] LOOP_TOP = 4'd7;
    localparam logic [PC_W-1:0] END_PC   = 4'd12;
    localparam logic [1:0]      COMP_LAST = 2'(NUM_COMPS - 1);

    // Program: weights first, then one multiply-accumulate loop per coordinate
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t uc;
        case (pc)
            4'd0:  uc = '{A_S,    2'd0, B_S,     WB_NONE,     SEQ_NEXT};
            4'd1:  uc = '{A_U,    2'd0, B_U,     WB_S2,       SEQ_NEXT};
            4'd2:  uc = '{A_S2,   2'd0, B_S,     WB_U2,       SEQ_NEXT};
            4'd3:  uc = '{A_U2,   2'd0, B_U,     WB_W3,       SEQ_NEXT};
            4'd4:  uc = '{A_3S,   2'd0, B_U2,    WB_W0,       SEQ_NEXT};
            4'd5:  uc = '{A_3U,   2'd0, B_S2,    WB_W1,       SEQ_NEXT};
            4'd6:  uc = '{A_ZERO, 2'd0, B_S,     WB_W2,       SEQ_NEXT};
            4'd7:  uc = '{A_WGT,  2'd0, B_COORD, WB_NONE,     SEQ_NEXT};
            4'd8:  uc = '{A_WGT,  2'd1, B_COORD, WB_ACC_LOAD, SEQ_NEXT};
            4'd9:  uc = '{A_WGT,  2'd2, B_COORD, WB_ACC_ADD,  SEQ_NEXT};
            4'd10: uc = '{A_WGT,  2'd3, B_COORD, WB_ACC_ADD,  SEQ_NEXT};
            4'd11: uc = '{A_ZERO, 2'd0, B_S,     WB_ACC_ADD,  SEQ_LOOP};
            4'd12: uc = '{A_ZERO, 2'd0, B_S,     WB_NONE,     SEQ_END};
            default: uc = '{A_ZERO, 2'd0, B_S,   WB_NONE,     SEQ_END};
        endcase
        return uc;
    endfunction

endpackage

// ===== hdl/cubic_bezier_point_evaluator.sv =====
// Cubic Bezier point evaluator: microcoded sequencer over one shared multiplier.
// Depends on cbpe_pkg and cubic_bezier_point_evaluator_assert.svh.
`timescale 1ns / 1ps
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------------
//  s_      | s_valid / s_ready      | s_sample_index, s_clear_highest
//  m_      | m_valid / m_ready      | m_point_x/y/z, m_is_new_highest,
//          |                        | m_highest_y, m_highest_time
//  cfg_    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  An input beat is accepted while idle and then runs 23 sequencer steps:
//  7 steps build the four weights and 3 x 5 steps run the multiply-accumulate loop,
//  all through the single 23x17 multiplier, then one step rounds and updates the
//  tracker. s_ready is high only between items; the result register lets the next
//  item start while a result waits. A stalled m_ side holds the final step.
//  Synchronous active-low reset clears control, config and the tracker.

module cubic_bezier_point_evaluator (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input beats
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [cbpe_pkg::IDX_W-1:0]        s_sample_index,
    input  logic                              s_clear_highest,
    // result beats
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [cbpe_pkg::COORD_BITS-1:0] m_point_x,
    output logic signed [cbpe_pkg::COORD_BITS-1:0] m_point_y,
    output logic signed [cbpe_pkg::COORD_BITS-1:0] m_point_z,
    output logic                              m_is_new_highest,
    output logic signed [cbpe_pkg::COORD_BITS-1:0] m_highest_y,
    output logic [cbpe_pkg::TIME_W-1:0]       m_highest_time,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cbpe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cbpe_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import cbpe_pkg::*;

`include "cubic_bezier_point_evaluator_assert.svh"

    typedef enum logic {ST_IDLE, ST_RUN} seq_state_t;

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) <<< (FRAC_W - 1);
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

    // Sequencer and datapath registers
    seq_state_t                state_reg;
    logic [PC_W-1:0]           pc_reg;
    logic [1:0]                comp_reg;
    logic [SAMP_W-1:0]         s_reg;
    logic [SAMP_W-1:0]         u_reg;
    logic                      clr_reg;
    logic [SQ_W-1:0]           s2_reg;
    logic [SQ_W-1:0]           u2_reg;
    logic [WGT_W-1:0]          w_reg [NUM_POINTS];
    logic signed [ACC_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]   acc_reg [NUM_COMPS];

    // Configuration
    logic [CFG_DATA_W-1:0]     point_reg [NUM_POINTS];
    logic [SEG_W-1:0]          seg_reg;

    // Tracker (only height and time are observable)
    logic signed [COORD_BITS-1:0] high_y_reg;
    logic [TIME_W-1:0]            high_time_reg;

    // Result register
    logic                         m_valid_reg;
    logic signed [COORD_BITS-1:0] m_point_reg [NUM_COMPS];
    logic                         m_new_reg;
    logic signed [COORD_BITS-1:0] m_high_y_reg;
    logic [TIME_W-1:0]            m_high_time_reg;

    ucode_t                    uc;
    logic [WGT_W-1:0]          op_a;
    logic signed [OPB_W-1:0]   op_b;
    logic signed [PROD_W-1:0]  prod_full;
    logic [TRI_W-1:0]          tri_s;
    logic [TRI_W-1:0]          tri_u;
    logic [COORD_BITS-1:0]     coord_bits;
    logic [SAMP_W-1:0]         s_clamped;
    logic signed [COORD_BITS-1:0] res [NUM_COMPS];
    logic signed [COORD_BITS-1:0] base_y;
    logic [TIME_W-1:0]         base_time;
    logic [TIME_W-1:0]         cur_time;
    logic                      is_new;
    logic                      fin_go;

    assign uc        = ucode_rom(pc_reg);
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // Clamp the sample index to t = 1
    assign s_clamped = (s_sample_index > IDX_W'(STEPS)) ? SAMP_W'(STEPS)
                                                       : SAMP_W'(s_sample_index);

    // Multiplier operand selection
    assign tri_s      = (TRI_W'(s_reg) << 1) + TRI_W'(s_reg);
    assign tri_u      = (TRI_W'(u_reg) << 1) + TRI_W'(u_reg);
    assign coord_bits = point_reg[uc.pt][comp_reg*COORD_BITS +: COORD_BITS];

    always_comb begin
        case (uc.a_sel)
            A_S:     op_a = WGT_W'(s_reg);
            A_U:     op_a = WGT_W'(u_reg);
            A_S2:    op_a = WGT_W'(s2_reg);
            A_U2:    op_a = WGT_W'(u2_reg);
            A_3S:    op_a = WGT_W'(tri_s);
            A_3U:    op_a = WGT_W'(tri_u);
            A_WGT:   op_a = w_reg[uc.pt];
            default: op_a = '0;
        endcase
    end

    always_comb begin
        case (uc.b_sel)
            B_U:     op_b = signed'(OPB_W'(u_reg));
            B_S2:    op_b = signed'(OPB_W'(s2_reg));
            B_U2:    op_b = signed'(OPB_W'(u2_reg));
            B_COORD: op_b = signed'({coord_bits[COORD_BITS-1], coord_bits});
            default: op_b = signed'(OPB_W'(s_reg));
        endcase
    end

    assign prod_full = signed'({1'b0, op_a}) * op_b;

    // Round (bias already in the sum), floor shift, saturate
    always_comb begin
        logic signed [ACC_W-1:0]  shifted;
        logic signed [COORD_BITS:0] q;
        for (int c = 0; c < NUM_COMPS; c++) begin
            shifted = acc_reg[c] >>> FRAC_W;
            q       = shifted[COORD_BITS:0];
            if (q[COORD_BITS] != q[COORD_BITS-1]) begin
                res[c] = q[COORD_BITS] ? COORD_MIN : COORD_MAX;
            end else begin
                res[c] = q[COORD_BITS-1:0];
            end
        end
    end

    // Tracker compare against the (optionally cleared) stored height
    assign base_y    = clr_reg ? COORD_MIN : high_y_reg;
    assign base_time = clr_reg ? '0 : high_time_reg;
    assign cur_time  = (TIME_W'(seg_reg) << STEPS_LOG2) + TIME_W'(s_reg);
    assign is_new    = (res[1] > base_y);
    assign fin_go    = (state_reg == ST_RUN) && (uc.seq == SEQ_END)
                       && (!m_valid_reg || m_ready);

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_POINTS; i++) begin
                point_reg[i] <= '0;
            end
            seg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index) inside
                CFG_POINT_ZERO, CFG_POINT_ONE, CFG_POINT_TWO, CFG_POINT_THREE: begin
                    point_reg[cfg_index[1:0]] <= cfg_data;
                end
                CFG_SEGMENT_NUMBER: begin
                    seg_reg <= cfg_data[SEG_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // Datapath: product register and writeback of the previous product
    always_ff @(posedge aclk) begin
        prod_reg <= prod_full[ACC_W-1:0];
        if (state_reg == ST_RUN) begin
            case (uc.wb)
                WB_S2:       s2_reg <= prod_reg[SQ_W-1:0];
                WB_U2:       u2_reg <= prod_reg[SQ_W-1:0];
                WB_W0:       w_reg[0] <= prod_reg[WGT_W-1:0];
                WB_W1:       w_reg[1] <= prod_reg[WGT_W-1:0];
                WB_W2:       w_reg[2] <= prod_reg[WGT_W-1:0];
                WB_W3:       w_reg[3] <= prod_reg[WGT_W-1:0];
                WB_ACC_LOAD: acc_reg[comp_reg] <= prod_reg + ROUND_BIAS;
                WB_ACC_ADD:  acc_reg[comp_reg] <= acc_reg[comp_reg] + prod_reg;
                default: ;
            endcase
        end
    end

    // Sequencer, tracker and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            comp_reg      <= '0;
            clr_reg       <= 1'b0;
            high_y_reg    <= COORD_MIN;
            high_time_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            // a new result in the same cycle keeps valid up
            if (m_valid_reg && m_ready && !fin_go) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_RUN;
                        pc_reg    <= '0;
                        comp_reg  <= '0;
                        s_reg     <= s_clamped;
                        u_reg     <= SAMP_W'(STEPS) - s_clamped;
                        clr_reg   <= s_clear_highest;
                    end
                end
                ST_RUN: begin
                    unique case (uc.seq)
                        SEQ_NEXT: pc_reg <= pc_reg + 1'b1;
                        SEQ_LOOP: begin
                            if (comp_reg != COMP_LAST) begin
                                comp_reg <= comp_reg + 1'b1;
                                pc_reg   <= LOOP_TOP;
                            end else begin
                                pc_reg <= pc_reg + 1'b1;
                            end
                        end
                        SEQ_END: begin
                            if (fin_go) begin
                                state_reg       <= ST_IDLE;
                                high_y_reg      <= is_new ? res[1] : base_y;
                                high_time_reg   <= is_new ? cur_time : base_time;
                                m_valid_reg     <= 1'b1;
                                m_point_reg     <= res;
                                m_new_reg       <= is_new;
                                m_high_y_reg    <= is_new ? res[1] : base_y;
                                m_high_time_reg <= is_new ? cur_time : base_time;
                            end
                        end
                        default: pc_reg <= pc_reg;
                    endcase
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_point_x        = m_point_reg[0];
    assign m_point_y        = m_point_reg[1];
    assign m_point_z        = m_point_reg[2];
    assign m_is_new_highest = m_new_reg;
    assign m_highest_y      = m_high_y_reg;
    assign m_highest_time   = m_high_time_reg;

    // Checks
    `CBPE_ASSERT_NEXT(a_start_at_top, s_valid && s_ready, (state_reg == ST_RUN) && (pc_reg == '0) && (comp_reg == '0), "item did not start at step zero")
    `CBPE_ASSERT_NOW(a_comp_range, state_reg == ST_RUN, comp_reg <= COMP_LAST, "coordinate counter out of range")
    `CBPE_ASSERT_NEXT(a_loop_exit, (state_reg == ST_RUN) && (uc.seq == SEQ_LOOP) && (comp_reg == COMP_LAST), pc_reg == END_PC, "loop did not exit to final step")
    `CBPE_ASSERT_NOW(a_new_high_shown, m_valid && m_is_new_highest, m_highest_y == m_point_y, "new highest does not match point y")

endmodule
